>>> rtl/core/b64enc_pkg.sv
// Shared types, constants and the character mapping for the Base64 stream encoder.
package b64enc_pkg;

  // Default number of byte jobs buffered between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Fixed ASCII codes used by the encoder.
  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // Sextet range limits of the alphabet sections.
  localparam logic [5:0] SEXTET_LOWER = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;

  // Input request: one raw byte and its end-of-message flag.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } b64enc_in_t;

  // Output request: one ASCII character with its markers.
  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       message_end;
  } b64enc_out_t;

  // Work for one accepted byte: up to two sextets, then pad characters.
  typedef struct packed {
    logic [5:0] sextet0;
    logic [5:0] sextet1;
    logic [1:0] count_m1;   // number of characters minus one
    logic       last;
  } b64enc_job_t;

  // Maps a 6-bit value to its character of the standard alphabet.
  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < SEXTET_LOWER) begin
      return w + 8'd65;
    end else if (v < SEXTET_DIGIT) begin
      return w + 8'd71;
    end else if (v < SEXTET_PLUS) begin
      return w - 8'd4;
    end else if (v == SEXTET_PLUS) begin
      return CHAR_PLUS;
    end
    return CHAR_SLASH;
  endfunction

endpackage

>>> rtl/core/b64enc_front.sv
// Front end: accepts bytes, tracks the group phase and builds one job per byte.
module b64enc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  b64enc_pkg::b64enc_in_t in_data,
  input  logic                  queue_full,
  output logic                  push,
  output b64enc_pkg::b64enc_job_t push_job
);
  import b64enc_pkg::*;

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2,
    PH_3 = 2'd3
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] leftover_r, leftover_nxt;
  logic [7:0] b;

  assign b        = in_data.in_byte;
  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  // Split the byte into sextets according to its place in the group.
  always_comb begin
    push_job.last = in_data.last_byte;
    case (phase_r)
      PH_1: begin
        push_job.sextet0  = {leftover_r[1:0], b[7:4]};
        push_job.sextet1  = {b[3:0], 2'b00};
        push_job.count_m1 = in_data.last_byte ? 2'd2 : 2'd0;
        leftover_nxt      = b[3:0];
        phase_nxt         = PH_2;
      end
      PH_2: begin
        push_job.sextet0  = {leftover_r, b[7:6]};
        push_job.sextet1  = b[5:0];
        push_job.count_m1 = 2'd1;
        leftover_nxt      = 4'd0;
        phase_nxt         = PH_0;
      end
      default: begin
        push_job.sextet0  = b[7:2];
        push_job.sextet1  = {b[1:0], 4'b0000};
        push_job.count_m1 = in_data.last_byte ? 2'd3 : 2'd0;
        leftover_nxt      = {2'b00, b[1:0]};
        phase_nxt         = PH_1;
      end
    endcase
    // The end of a message always restarts a group.
    if (in_data.last_byte) begin
      leftover_nxt = 4'd0;
      phase_nxt    = PH_0;
    end
  end

  // Group state advances only on an accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_0;
      leftover_r <= 4'd0;
    end else if (push) begin
      phase_r    <= phase_nxt;
      leftover_r <= leftover_nxt;
    end
  end

endmodule

>>> rtl/core/b64enc_queue.sv
// Small job queue that decouples the front end from the character back end.
module b64enc_queue #(
  parameter int DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  b64enc_pkg::b64enc_job_t push_job,
  input  logic                    pop,
  output logic                    full,
  output logic                    head_valid,
  output b64enc_pkg::b64enc_job_t head_job
);
  import b64enc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64enc_job_t   entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = entries_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

>>> rtl/core/b64enc_back.sv
// Back end: walks the head job into the output register, one character per cycle unless the output stalls.
module b64enc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    head_valid,
  input  b64enc_pkg::b64enc_job_t head_job,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output b64enc_pkg::b64enc_out_t out_data
);
  import b64enc_pkg::*;

  logic [1:0]  idx_r;
  logic        out_valid_r;
  b64enc_out_t out_data_r;
  logic        load;
  logic        final_char;
  b64enc_out_t char_nxt;

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign load       = head_valid && (!out_valid_r || out_ready);
  assign final_char = (idx_r == head_job.count_m1);
  assign pop        = load && final_char;

  // Select the character at the current position of the job.
  always_comb begin
    case (idx_r)
      2'd0:    char_nxt.out_char = sextet_to_ascii(head_job.sextet0);
      2'd1:    char_nxt.out_char = sextet_to_ascii(head_job.sextet1);
      default: char_nxt.out_char = CHAR_PAD;
    endcase
    char_nxt.run_last    = final_char;
    char_nxt.message_end = final_char && head_job.last;
  end

  // Output register and character position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= final_char ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= char_nxt;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx_r <= head_job.count_m1)
    else $error("character position past end of job");
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.message_end |-> out_data_r.run_last)
    else $error("message end without run end");
  a_idx_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(idx_r))
    else $error("character position moved during stall");

endmodule

>>> rtl/core/base64_stream_encoder.sv
// Top level of the Base64 stream encoder: front end, job queue and back end.
// Accepts one raw byte per request and emits standard Base64 characters, one
// per output request; a byte marked last flushes its partial group with '='
// padding to four characters. A byte yields 1 or 2 characters (2 to 4 at a
// flush), and the back end emits one character per cycle from the output
// register unless the output stalls. The job queue (QUEUE_DEPTH entries) lets
// bytes be taken while earlier characters still wait; with the queue empty and
// the output register free, a byte's job is registered in the queue and its
// first character then in the output register. No clearing pass after reset.
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  b64enc_pkg::b64enc_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output b64enc_pkg::b64enc_out_t out_data
);
  import b64enc_pkg::*;

  logic        push;
  logic        pop;
  logic        queue_full;
  logic        head_valid;
  b64enc_job_t push_job;
  b64enc_job_t head_job;

  // Byte intake and group classification.
  b64enc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .queue_full(queue_full),
    .push      (push),
    .push_job  (push_job)
  );

  // Job buffer between the two halves.
  b64enc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (queue_full),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  // Character generation.
  b64enc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the Base64 stream encoder with a scoreboard and random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b64enc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BYTES   = 460;
  localparam int DRAIN_CYCLES   = 12;

  // Predicts the character stream from accepted bytes and checks what comes out.
  class char_scoreboard;
    b64enc_out_t expected_chars[$];
    logic [1:0]  group_pos;
    logic [3:0]  carry_bits;
    int          errors;
    string       alphabet;

    function new();
      group_pos  = 2'd0;
      carry_bits = 4'd0;
      errors     = 0;
      alphabet   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    endfunction

    function logic [7:0] encode(input logic [5:0] sextet);
      return alphabet[sextet];
    endfunction

    // Works out the characters that one accepted byte causes.
    function void note_byte(input b64enc_in_t req);
      logic [7:0]  chars [4];
      logic [7:0]  b;
      int          n;
      b64enc_out_t item;
      b = req.in_byte;
      n = 0;
      case (group_pos)
        2'd1: begin
          chars[0] = encode({carry_bits[1:0], b[7:4]});
          n = 1;
          carry_bits = b[3:0];
          group_pos = 2'd2;
          if (req.last_byte) begin
            chars[1] = encode({b[3:0], 2'b00});
            chars[2] = CHAR_PAD;
            n = 3;
          end
        end
        2'd2: begin
          chars[0] = encode({carry_bits, b[7:6]});
          chars[1] = encode(b[5:0]);
          n = 2;
          carry_bits = 4'd0;
          group_pos = 2'd0;
        end
        default: begin
          chars[0] = encode(b[7:2]);
          n = 1;
          carry_bits = {2'b00, b[1:0]};
          group_pos = 2'd1;
          if (req.last_byte) begin
            chars[1] = encode({b[1:0], 4'b0000});
            chars[2] = CHAR_PAD;
            chars[3] = CHAR_PAD;
            n = 4;
          end
        end
      endcase
      // A message end starts a fresh group.
      if (req.last_byte) begin
        group_pos = 2'd0;
        carry_bits = 4'd0;
      end
      for (int k = 0; k < n; k++) begin
        item.out_char    = chars[k];
        item.run_last    = (k == n - 1);
        item.message_end = (k == n - 1) && req.last_byte;
        expected_chars.push_back(item);
      end
    endfunction

    // Compares one emitted character with the oldest prediction.
    function void check_char(input b64enc_out_t got);
      b64enc_out_t want;
      if (expected_chars.size() == 0) begin
        $error("unexpected character: out_char=%h run_last=%b message_end=%b",
               got.out_char, got.run_last, got.message_end);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (got.out_char !== want.out_char) begin
        $error("out_char: expected %h, actual %h", want.out_char, got.out_char);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %b, actual %b", want.run_last, got.run_last);
        errors++;
      end
      if (got.message_end !== want.message_end) begin
        $error("message_end: expected %b, actual %b", want.message_end, got.message_end);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  b64enc_in_t  in_data;
  logic        out_valid;
  logic        out_ready;
  b64enc_out_t out_data;

  char_scoreboard sb;
  int             idle_cycles;
  bit             sender_busy_mode;

  base64_stream_encoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Monitor: records accepted requests, checks results and feeds the watchdog.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n && in_valid && in_ready) sb.note_byte(in_data);
      if (rst_n && out_valid && out_ready) sb.check_char(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  // Watchdog on cycles without any accepted request.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb: done, errors");
    $finish;
  end

  // Receiver: runs of readiness broken by stalls, with some long stall-free stretches.
  initial begin
    int run_len;
    int stall_len;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run_len) @(negedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(negedge clk);
      end
    end
  end

  // Sends one byte request; returns on the falling edge after it is accepted.
  task automatic push_byte(input logic [7:0] value, input logic is_last);
    int gap;
    gap = sender_busy_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: value, last_byte: is_last};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted character has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends a message of random bytes with the end flag on its final byte.
  task automatic push_message(input int len);
    logic [7:0] value;
    int         sel;
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) value = 8'h00;
      else if (sel == 1) value = 8'hFF;
      else value = $urandom_range(0, 255);
      push_byte(value, i == len - 1);
    end
  endtask

  // Directed messages: extreme bytes, flush at every group position, '+' and '/'.
  logic [7:0] directed_bytes [21] = '{
    8'h00,
    8'hFF,
    8'hF8,
    8'hFC,
    8'h00, 8'h00,
    8'hFF, 8'hFF,
    8'h00, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF,
    8'hFB, 8'hEF, 8'hBE,
    8'h4D, 8'h61, 8'h6E, 8'h4D
  };
  bit directed_ends [21] = '{
    1,
    1,
    1,
    1,
    0, 1,
    0, 1,
    0, 0, 1,
    0, 0, 1,
    0, 0, 1,
    0, 0, 0, 1
  };

  // Main sequence: reset, directed part, random messages, drain and verdict.
  initial begin
    int sent;
    int len;
    int r;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    sender_busy_mode = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < 21; i++) begin
      push_byte(directed_bytes[i], directed_ends[i]);
    end
    wait_drained();

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 95) len = $urandom_range(9, 30);
      else len = $urandom_range(31, 80);
      sender_busy_mode = ($urandom_range(0, 3) == 0);
      push_message(len);
      sent += len;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    sender_busy_mode = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
